// File: hw/rtl/lsi_pkg.sv
package lsi_pkg;

  // Stack geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the transactions
  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int ECNT_W = 5;
  localparam int STAT_W = 2;

  // Width that holds both a position and a count for compares
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Raw command codes on the input port
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_INSERT,
    OP_PEEK,
    OP_DUMP,
    OP_NOP
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_POS   = 2'd3
  } status_t;

  // Back end sequencer
  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } back_state_t;

  // One classified command
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
  } cmd_rec_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             dumping;
  } back_stat_t;

  // Queue status
  typedef struct packed {
    logic              full;
  } queue_stat_t;

endpackage

// File: hw/rtl/lsi_front.sv
module lsi_front (
  input  logic                         in_valid,
  input  logic [lsi_pkg::CMD_W-1:0]    cmd,
  input  logic signed [lsi_pkg::DATA_W-1:0] data_in,
  input  logic [lsi_pkg::POS_W-1:0]    position,
  output logic                         in_stall,
  input  lsi_pkg::queue_stat_t         q_stat,
  output logic                         q_push,
  output lsi_pkg::cmd_rec_t            q_rec
);
  import lsi_pkg::*;

  // Accept whenever the queue has room
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // Classify the command; unused codes become a no-op
  always_comb begin
    q_rec.data     = data_in;
    q_rec.position = position;
    unique case (cmd)
      CMD_PUSH:   q_rec.op = OP_PUSH;
      CMD_POP:    q_rec.op = OP_POP;
      CMD_INSERT: q_rec.op = OP_INSERT;
      CMD_PEEK:   q_rec.op = OP_PEEK;
      CMD_DUMP:   q_rec.op = OP_DUMP;
      default:    q_rec.op = OP_NOP;
    endcase
  end

endmodule

// File: hw/rtl/lsi_queue.sv
module lsi_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  lsi_pkg::cmd_rec_t    wr_rec,
  output lsi_pkg::queue_stat_t stat,
  output logic                 rd_valid,
  output lsi_pkg::cmd_rec_t    rd_rec,
  input  logic                 rd
);
  import lsi_pkg::*;

  cmd_rec_t           slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QLVL_W-1:0]  level;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign stat.full  = (level == QLVL_W'(QDEPTH));
  assign rd_valid   = (level != '0);
  assign rd_rec     = slots[rd_ptr];

  // Payload store
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr && !rd) begin
        level <= level + QLVL_W'(1);
      end else if (rd && !wr) begin
        level <= level - QLVL_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lsi_back.sv
module lsi_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  lsi_pkg::cmd_rec_t                 q_rec,
  output logic                              q_take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lsi_pkg::DATA_W-1:0] data_out,
  output logic [lsi_pkg::ECNT_W-1:0]        entry_count,
  output logic [lsi_pkg::STAT_W-1:0]        status,
  output logic                              last,
  output lsi_pkg::back_stat_t               stat
);
  import lsi_pkg::*;

  // Stack words, index 0 is the bottom
  logic signed [DATA_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]         count, count_next;
  back_state_t              state, state_next;
  logic [IDX_W-1:0]         dump_idx, dump_idx_next;

  // Output register and its next values
  logic                     out_valid_next;
  logic signed [DATA_W-1:0] data_reg, data_next;
  status_t                  status_reg, status_next;
  logic                     last_next;
  logic [ECNT_W-1:0]        ecnt_reg;

  // Write port of the stack
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_slot;

  logic                     adv;
  logic                     is_full, is_empty, pos_bad;
  logic [IDX_W-1:0]         top_idx, rd_idx;
  logic signed [DATA_W-1:0] rd_data;
  logic [CMP_W-1:0]         slot_w;

  assign adv      = !out_valid || !out_stall;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign pos_bad  = (CMP_W'(q_rec.position) > CMP_W'(count));
  assign slot_w   = CMP_W'(count) - CMP_W'(q_rec.position);
  assign top_idx  = IDX_W'(count - CNT_W'(1));
  assign rd_idx   = (state == BK_DUMP) ? dump_idx : top_idx;
  assign rd_data  = entries[rd_idx];
  assign q_take   = q_valid && (state == BK_RUN) && adv;

  assign data_out     = data_reg;
  assign status       = status_reg;
  assign entry_count  = ecnt_reg;
  assign stat.count   = count;
  assign stat.dumping = (state == BK_DUMP);

  // Command execution and dump sequencing
  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_idx_next  = dump_idx;
    out_valid_next = out_valid;
    data_next      = data_reg;
    status_next    = status_reg;
    last_next      = last;
    wr_en          = 1'b0;
    wr_slot        = IDX_W'(count);
    if (adv) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      BK_RUN: begin
        if (q_take) begin
          out_valid_next = 1'b1;
          data_next      = '0;
          status_next    = ST_OK;
          last_next      = 1'b1;
          unique case (q_rec.op)
            OP_PUSH: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else if (pos_bad) begin
                status_next = ST_POS;
              end else begin
                wr_en      = 1'b1;
                wr_slot    = IDX_W'(slot_w);
                count_next = count + CNT_W'(1);
              end
            end
            OP_PEEK: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                data_next = rd_data;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                data_next = rd_data;
                if (count != CNT_W'(1)) begin
                  last_next     = 1'b0;
                  state_next    = BK_DUMP;
                  dump_idx_next = top_idx - IDX_W'(1);
                end
              end
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      BK_DUMP: begin
        if (adv) begin
          out_valid_next = 1'b1;
          data_next      = rd_data;
          status_next    = ST_OK;
          last_next      = (dump_idx == '0);
          if (dump_idx == '0) begin
            state_next = BK_RUN;
          end else begin
            dump_idx_next = dump_idx - IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload and dump index
  always_ff @(posedge clk) begin
    dump_idx   <= dump_idx_next;
    data_reg   <= data_next;
    status_reg <= status_next;
    last       <= last_next;
    ecnt_reg   <= ECNT_W'(count_next);
  end

  // Stack words: parallel shift up above the write slot
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_word
    if (gi == 0) begin : g_bottom
      always_ff @(posedge clk) begin
        if (wr_en && (wr_slot == IDX_W'(gi))) begin
          entries[gi] <= q_rec.data;
        end
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        if (wr_en) begin
          if (wr_slot == IDX_W'(gi)) begin
            entries[gi] <= q_rec.data;
          end else if ((IDX_W'(gi) > wr_slot) && (CNT_W'(gi) <= count)) begin
            entries[gi] <= entries[gi-1];
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/lifo_stack_with_insert_unit.sv
// Bounded LIFO of signed 32-bit words with push, pop, insert at depth,
// peek and dump.
// Input channel (in_valid / in_stall): one command per transaction with
// cmd, data_in and position. Output channel (out_valid / out_stall): result
// transactions carrying data_out, entry_count, status and last.
// Every command gives one result, except dump on a non-empty stack, which
// gives one result per entry from top to bottom with last on the bottom one.
// An accepted command is registered in the queue; the back end executes it and
// registers the result. During a dump the back end reads one stack word per cycle
// while no result is stalled. Insert is a parallel shift of the register stack
// words above the write slot.
// A two-entry command queue sits between the decode front and the back end,
// so commands keep being accepted while a result waits on out_stall.
// A stalled result holds the back end; the queue then fills and raises
// in_stall. Reset (rst, synchronous) empties the stack and the queue and
// drops out_valid; stack words hold no reset value.
module lifo_stack_with_insert_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lsi_pkg::CMD_W-1:0]         cmd,
  input  logic signed [lsi_pkg::DATA_W-1:0] data_in,
  input  logic [lsi_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lsi_pkg::DATA_W-1:0] data_out,
  output logic [lsi_pkg::ECNT_W-1:0]        entry_count,
  output logic [lsi_pkg::STAT_W-1:0]        status,
  output logic                              last
);
  import lsi_pkg::*;

  logic        q_push, q_valid, q_take;
  cmd_rec_t    fe_rec, q_rec;
  queue_stat_t q_stat;
  back_stat_t  bk_stat;

  // Decode front
  lsi_front u_front (
    .in_valid (in_valid),
    .cmd      (cmd),
    .data_in  (data_in),
    .position (position),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_rec    (fe_rec)
  );

  // Command queue
  lsi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_rec   (fe_rec),
    .stat     (q_stat),
    .rd_valid (q_valid),
    .rd_rec   (q_rec),
    .rd       (q_take)
  );

  // Stack and result sequencer
  lsi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_rec       (q_rec),
    .q_take      (q_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .entry_count (entry_count),
    .status      (status),
    .last        (last),
    .stat        (bk_stat)
  );

  // Stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bk_stat.count <= CNT_W'(DEPTH))
    else $error("stack count above depth");

  // A full status is only reported while the stack is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (bk_stat.count == CNT_W'(DEPTH)))
    else $error("full status with room left");

  // During a dump a result is always pending and it is not the last one
  a_dump_pending: assert property (@(posedge clk) disable iff (rst)
    bk_stat.dumping |-> (out_valid && !last))
    else $error("dump sequencing lost a result");

  // No command leaves the queue during a dump, so the stack count stays unchanged
  a_dump_hold: assert property (@(posedge clk) disable iff (rst)
    bk_stat.dumping |=> (bk_stat.count == $past(bk_stat.count)))
    else $error("stack changed during dump");

endmodule

// File: test/tb_lifo_stack_with_insert_unit.sv
`timescale 1ns / 100ps

module tb_lifo_stack_with_insert_unit;
  import lsi_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RST_CYCLES   = 6;
  localparam int HOLD_CYCLES  = 60;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RAND_ITEMS   = 480;
  localparam int END_CYCLES   = 8;

  // Unused command codes, sent as noise
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // One expected result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ECNT_W-1:0]        cnt;
    status_t                  st;
    logic                     last;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic signed [DATA_W-1:0] data_in = '0;
  logic [POS_W-1:0]         position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] data_out;
  logic [ECNT_W-1:0]        entry_count;
  logic [STAT_W-1:0]        status;
  logic                     last;

  // Shadow stack: index 0 is the bottom, held-1 the top
  logic signed [DATA_W-1:0] shadow_stk [DEPTH];
  int                       held = 0;
  stack_result_t            pending_results [$];

  int errors    = 0;
  int cycles    = 0;
  bit idle_en   = 1'b1;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  lifo_stack_with_insert_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_in    (data_in),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .entry_count(entry_count),
    .status     (status),
    .last       (last)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(0, 99) < 20);
    end
  end

  // Result checker
  always @(posedge clk) begin
    stack_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data_out=%h entry_count=%0d status=%0d last=%0d",
                 $time, data_out, entry_count, status, last);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (data_out !== e.data) begin
          $display("%0t: data_out expected %h, actual %h", $time, e.data, data_out);
          errors++;
        end
        if (entry_count !== e.cnt) begin
          $display("%0t: entry_count expected %0d, actual %0d", $time, e.cnt, entry_count);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d, actual %0d", $time, e.st, status);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0d, actual %0d", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  // Queue one expected result at the current count
  function automatic void add_result(input logic signed [DATA_W-1:0] d, input status_t st,
                                     input logic lst);
    stack_result_t r;
    r.data = d;
    r.cnt  = ECNT_W'(held);
    r.st   = st;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow stack and queue its results
  function automatic void predict_stack_op(input logic [CMD_W-1:0] c,
                                           input logic signed [DATA_W-1:0] d,
                                           input logic [POS_W-1:0] p);
    int slot;
    case (c)
      CMD_PUSH: begin
        if (held >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          shadow_stk[held] = d;
          held++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          held--;
          add_result('0, ST_OK, 1'b1);
        end
      end
      CMD_INSERT: begin
        // full wins over a bad position
        if (held >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else if (int'(p) > held) begin
          add_result('0, ST_POS, 1'b1);
        end else begin
          slot = held - int'(p);
          for (int i = held; i > slot; i--) shadow_stk[i] = shadow_stk[i-1];
          shadow_stk[slot] = d;
          held++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      CMD_PEEK: begin
        if (held == 0) add_result('0, ST_EMPTY, 1'b1);
        else add_result(shadow_stk[held-1], ST_OK, 1'b1);
      end
      CMD_DUMP: begin
        if (held == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = held; i > 0; i--) add_result(shadow_stk[i-1], ST_OK, i == 1);
        end
      end
      default: add_result('0, ST_OK, 1'b1);
    endcase
  endfunction

  // Send one command transaction; returns at the edge that accepts it
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] d,
                          input logic [POS_W-1:0] p);
    if (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    data_in  <= d;
    position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stack_op(c, d, p);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
  endtask

  // Empty-stack cases, value extremes, every command and bad positions
  task automatic test_directed_edges();
    send_cmd(CMD_POP,    32'sd0, 5'd0);
    send_cmd(CMD_PEEK,   32'sd0, 5'd0);
    send_cmd(CMD_DUMP,   32'sd0, 5'd0);
    send_cmd(CMD_INSERT, 32'sh0bad_0bad, 5'd1);
    send_cmd(CMD_INSERT, 32'sh1234_5678, 5'd0);
    send_cmd(CMD_PUSH,   32'sh7fff_ffff, 5'd0);
    send_cmd(CMD_PUSH,   32'sh8000_0000, 5'd31);
    send_cmd(CMD_PEEK,   32'sd0, 5'd0);
    // position equal to count lands at the bottom
    send_cmd(CMD_INSERT, -32'sd1, 5'd3);
    send_cmd(CMD_INSERT, 32'sh5555_aaaa, 5'd31);
    send_cmd(CMD_INSERT, 32'sh5555_aaaa, 5'd5);
    send_cmd(CMD_SPARE5, 32'shffff_ffff, 5'd31);
    send_cmd(CMD_SPARE6, 32'sd0, 5'd16);
    send_cmd(CMD_SPARE7, 32'sh0f0f_0f0f, 5'd7);
    send_cmd(CMD_INSERT, 32'sh0000_0001, 5'd2);
    send_cmd(CMD_DUMP,   32'sd0, 5'd0);
    send_cmd(CMD_POP,    32'sd0, 5'd0);
    send_cmd(CMD_PEEK,   32'sd0, 5'd0);
  endtask

  // Fill to full while the receiver holds off, then full cases and a full dump
  task automatic test_full_backpressure();
    hold_reqs <= hold_reqs + 1;
    while (held < DEPTH) begin
      if ($urandom_range(0, 1)) send_cmd(CMD_PUSH, $urandom, 5'($urandom));
      else send_cmd(CMD_INSERT, $urandom, 5'($urandom_range(0, held)));
    end
    send_cmd(CMD_PUSH,   32'sh7fff_ffff, 5'd0);
    send_cmd(CMD_INSERT, 32'sh8000_0000, 5'd31);
    send_cmd(CMD_INSERT, 32'sh8000_0000, 5'd0);
    send_cmd(CMD_PEEK,   32'sd0, 5'd0);
    send_cmd(CMD_DUMP,   32'sd0, 5'd0);
  endtask

  // Random traffic in grow and shrink phases, with one stretch of no idling
  task automatic test_random_traffic(input int n_items);
    logic [CMD_W-1:0]         c;
    logic signed [DATA_W-1:0] d;
    logic [POS_W-1:0]         p;
    int                       roll;
    bit                       grow;
    grow = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) grow = !grow;
      if (i == 200) idle_en <= 1'b0;
      if (i == 280) idle_en <= 1'b1;
      roll = $urandom_range(0, 99);
      if (grow) begin
        if (roll < 40)      c = CMD_PUSH;
        else if (roll < 70) c = CMD_INSERT;
        else if (roll < 78) c = CMD_POP;
        else if (roll < 86) c = CMD_PEEK;
        else if (roll < 94) c = CMD_DUMP;
        else                c = CMD_W'($urandom_range(0, 7));
      end else begin
        if (roll < 10)      c = CMD_PUSH;
        else if (roll < 20) c = CMD_INSERT;
        else if (roll < 60) c = CMD_POP;
        else if (roll < 72) c = CMD_PEEK;
        else if (roll < 84) c = CMD_DUMP;
        else                c = CMD_W'($urandom_range(0, 7));
      end
      roll = $urandom_range(0, 99);
      if (roll < 10)      d = 32'sh7fff_ffff;
      else if (roll < 20) d = 32'sh8000_0000;
      else if (roll < 25) d = 32'sd0;
      else if (roll < 30) d = -32'sd1;
      else                d = $urandom;
      // mostly legal depths for insert, sometimes anything
      if (c == CMD_INSERT && $urandom_range(0, 99) < 85) p = POS_W'($urandom_range(0, held));
      else p = POS_W'($urandom_range(0, 31));
      send_cmd(c, d, p);
    end
  endtask

  // Test sequence
  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    wait_all_results();
    test_full_backpressure();
    wait_all_results();
    test_random_traffic(RAND_ITEMS);
    wait_all_results();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: lifo_stack_with_insert_unit.f
hw/rtl/lsi_pkg.sv
hw/rtl/lsi_front.sv
hw/rtl/lsi_queue.sv
hw/rtl/lsi_back.sv
hw/rtl/lifo_stack_with_insert_unit.sv
test/tb_lifo_stack_with_insert_unit.sv
